@@ rtl/mwdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mwdc_pkg
// Shared types and fixed field widths for the minimum covering window search.
// ----------------------------------------------------------------------------
package mwdc_pkg;

    // fixed widths of the item and result fields
    localparam int SYM_W   = 8;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;

    // depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_PAT  = 2'd0,
        CMD_TEXT = 2'd1,
        CMD_TOVF = 2'd2
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t          kind;
        logic [SYM_W-1:0]   sym;
        logic               last;
    } cmd_t;

endpackage

@@ rtl/mwdc_front.sv @@
// ----------------------------------------------------------------------------
// mwdc_front
// Classifies incoming bytes into pattern loads, text bytes and overflowed text,
// drops pattern bytes that arrive after text, and forwards commands.
// ----------------------------------------------------------------------------
module mwdc_front #(
    parameter int MAX_TEXT = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        operation,
    input  logic [mwdc_pkg::SYM_W-1:0]  symbol,
    input  logic                        last,
    output logic                        q_push,
    output mwdc_pkg::cmd_t              q_data
);
    import mwdc_pkg::*;

    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam logic [PW-1:0] TEXT_CAP = PW'(MAX_TEXT);

    logic [PW-1:0] text_cnt_reg;
    logic [PW-1:0] text_cnt_next;
    logic          cnt_room;

    assign cnt_room = text_cnt_reg < TEXT_CAP;

    // classify the byte
    always_comb
    begin
        q_data.sym  = symbol;
        q_data.last = operation & last;
        if (!operation)
        begin
            q_data.kind = CMD_PAT;
        end
        else if (cnt_room)
        begin
            q_data.kind = CMD_TEXT;
        end
        else
        begin
            q_data.kind = CMD_TOVF;
        end
    end

    // pattern bytes after any text in the search carry no work
    assign q_push = take && (operation || (text_cnt_reg == '0));

    // text count of the current search, mirrors the back right edge
    always_comb
    begin
        text_cnt_next = text_cnt_reg;
        if (take && operation)
        begin
            if (last)
            begin
                text_cnt_next = '0;
            end
            else if (cnt_room)
            begin
                text_cnt_next = text_cnt_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_cnt_reg <= '0;
        end
        else
        begin
            text_cnt_reg <= text_cnt_next;
        end
    end

endmodule

@@ rtl/mwdc_queue.sv @@
// ----------------------------------------------------------------------------
// mwdc_queue
// Short command queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module mwdc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mwdc_pkg::cmd_t  wr_data,
    input  logic            pop,
    output mwdc_pkg::cmd_t  rd_data,
    output logic            full,
    output logic            empty
);
    import mwdc_pkg::*;

    cmd_t             slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == (QAW+1)'(QDEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QAW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QAW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/mwdc_back.sv @@
// ----------------------------------------------------------------------------
// mwdc_back
// Search engine: need table, text buffer, window pointers and result register.
// Walks the left edge one step at a time through read-modify-write cycles.
// ----------------------------------------------------------------------------
module mwdc_back #(
    parameter int MAX_TEXT = 4096,
    parameter int ALPHABET = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  mwdc_pkg::cmd_t                q_data,
    output logic                          q_pop,
    input  logic                          res_pop,
    output logic                          res_valid,
    output logic                          res_found,
    output logic [mwdc_pkg::START_W-1:0]  res_start,
    output logic [mwdc_pkg::LEN_W-1:0]    res_len,
    output logic                          res_ovf
);
    import mwdc_pkg::*;

    localparam int AW = $clog2(MAX_TEXT);
    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam int NW = $clog2(MAX_TEXT + 2) + 1;
    localparam int KW = $clog2(ALPHABET + 1);
    localparam int SW = $clog2(ALPHABET);
    localparam int SYMS = 1 << SYM_W;
    localparam logic signed [NW-1:0] NEED_MAX = NW'(MAX_TEXT);
    localparam logic signed [NW-1:0] NEED_CAP = NW'(MAX_TEXT + 1);
    localparam logic signed [NW-1:0] NEED_ONE = NW'(1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PAT  = 7'b0000010,
        S_TDEC = 7'b0000100,
        S_LOOP = 7'b0001000,
        S_LBUF = 7'b0010000,
        S_LINC = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    // byte to need table index
    logic [SW-1:0] mod_tab [SYMS];
    for (genvar g = 0; g < SYMS; g++)
    begin : g_mod
        localparam int unsigned MODV = g % ALPHABET;
        assign mod_tab[g] = SW'(MODV);
    end

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [KW-1:0]        missing_reg, missing_next;
    logic [PW-1:0]        left_reg, left_next;
    logic [PW-1:0]        right_reg, right_next;
    logic [AW-1:0]        best_start_reg, best_start_next;
    logic [PW-1:0]        best_len_reg, best_len_next;
    logic                 ovf_reg, ovf_next;

    logic                 res_valid_reg;
    logic                 res_found_reg;
    logic [START_W-1:0]   res_start_reg;
    logic [LEN_W-1:0]     res_len_reg;
    logic                 res_ovf_reg;
    logic                 res_load;
    logic                 clear;

    // need table and its valid bits
    logic signed [NW-1:0] need_mem [ALPHABET];
    logic [ALPHABET-1:0]  need_valid_reg;
    logic signed [NW-1:0] need_rd_reg;
    logic                 need_rd_vld_reg;
    logic [SW-1:0]        need_addr_reg;
    logic [SW-1:0]        need_raddr;
    logic                 need_we;
    logic signed [NW-1:0] need_wdata;
    logic signed [NW-1:0] cur_need;
    logic signed [NW-1:0] need_inc;
    logic signed [NW-1:0] need_dec;

    // text buffer
    logic [SYM_W-1:0]     buf_mem [MAX_TEXT];
    logic [SYM_W-1:0]     buf_rd_reg;
    logic                 buf_we;

    logic [PW-1:0]        win_len;

    assign cur_need = need_rd_vld_reg ? need_rd_reg : '0;
    assign need_inc = cur_need + NEED_ONE;
    assign need_dec = cur_need - NEED_ONE;
    assign win_len  = right_reg - left_reg + PW'(1);

    // search sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        missing_next    = missing_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        q_pop           = 1'b0;
        need_raddr      = need_addr_reg;
        need_we         = 1'b0;
        need_wdata      = need_inc;
        buf_we          = 1'b0;
        res_load        = 1'b0;
        clear           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    need_raddr = mod_tab[q_data.sym];
                    case (q_data.kind)
                        CMD_PAT:
                        begin
                            state_next = S_PAT;
                        end
                        CMD_TEXT:
                        begin
                            buf_we = 1'b1;
                            if (missing_reg != '0)
                            begin
                                state_next = S_TDEC;
                            end
                            else
                            begin
                                right_next = right_reg + PW'(1);
                                state_next = q_data.last ? S_EMIT : S_IDLE;
                            end
                        end
                        CMD_TOVF:
                        begin
                            ovf_next   = 1'b1;
                            state_next = q_data.last ? S_EMIT : S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PAT:
            begin
                need_we = 1'b1;
                if (cur_need >= NEED_MAX)
                begin
                    need_wdata = NEED_CAP;
                    ovf_next   = 1'b1;
                end
                else
                begin
                    need_wdata = need_inc;
                    if (cur_need == '0)
                    begin
                        missing_next = missing_reg + KW'(1);
                    end
                end
                state_next = S_IDLE;
            end
            S_TDEC:
            begin
                need_we    = 1'b1;
                need_wdata = need_dec;
                if (need_dec == '0)
                begin
                    missing_next = missing_reg - KW'(1);
                end
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if ((missing_reg == '0) && (left_reg <= right_reg))
                begin
                    if ((best_len_reg == '0) || (win_len < best_len_reg))
                    begin
                        best_len_next   = win_len;
                        best_start_next = left_reg[AW-1:0];
                    end
                    state_next = S_LBUF;
                end
                else
                begin
                    right_next = right_reg + PW'(1);
                    state_next = cmd_reg.last ? S_EMIT : S_IDLE;
                end
            end
            S_LBUF:
            begin
                need_raddr = mod_tab[buf_rd_reg];
                state_next = S_LINC;
            end
            S_LINC:
            begin
                need_we    = 1'b1;
                need_wdata = need_inc;
                if (!need_inc[NW-1] && (need_inc != '0))
                begin
                    missing_next = missing_reg + KW'(1);
                end
                left_next  = left_reg + PW'(1);
                state_next = S_LOOP;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    res_load        = 1'b1;
                    clear           = 1'b1;
                    missing_next    = '0;
                    left_next       = '0;
                    right_next      = '0;
                    best_start_next = '0;
                    best_len_next   = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // need table storage, registered read
    always_ff @(posedge clk)
    begin
        if (need_we)
        begin
            need_mem[need_addr_reg] <= need_wdata;
        end
        need_rd_reg <= need_mem[need_raddr];
    end

    // text buffer storage, registered read at the left edge
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[right_reg[AW-1:0]] <= q_data.sym;
        end
        buf_rd_reg <= buf_mem[left_reg[AW-1:0]];
    end

    // command register
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_found_reg <= best_len_reg != '0;
            res_start_reg <= START_W'(best_start_reg);
            res_len_reg   <= LEN_W'(best_len_reg);
            res_ovf_reg   <= ovf_reg;
        end
    end

    // control state, valid bits and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            missing_reg     <= '0;
            left_reg        <= '0;
            right_reg       <= '0;
            best_start_reg  <= '0;
            best_len_reg    <= '0;
            ovf_reg         <= 1'b0;
            need_valid_reg  <= '0;
            need_rd_vld_reg <= 1'b0;
            need_addr_reg   <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            missing_reg     <= missing_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            best_start_reg  <= best_start_next;
            best_len_reg    <= best_len_next;
            ovf_reg         <= ovf_next;
            need_addr_reg   <= need_raddr;
            need_rd_vld_reg <= need_valid_reg[need_raddr];
            if (clear)
            begin
                need_valid_reg <= '0;
            end
            else if (need_we)
            begin
                need_valid_reg[need_addr_reg] <= 1'b1;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_found = res_found_reg;
    assign res_start = res_start_reg;
    assign res_len   = res_len_reg;
    assign res_ovf   = res_ovf_reg;

endmodule

@@ rtl/min_window_distinct_cover.sv @@
// ----------------------------------------------------------------------------
// min_window_distinct_cover
// Shortest text window that covers every pattern byte with multiplicity.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  items     in         push / full   operation, symbol, last
//  results   out        empty / pop   found, window_start, window_length, overflow
//
//  a pattern byte takes a need table read, then a write in the back
//  a text byte takes a need table read and write (only buffered with no
//  pattern loaded, only flagged past the buffer), plus a buffer read, a
//  need table read and a need table write for each left edge step, then a
//  step to post the result on last (single-port need table read-modify-write)
//  no clearing pass after reset: the need table uses per-entry valid bits
//  a 4-entry queue lets items arrive while the back works; a waiting result
//  holds the back only when the next result is ready
// ----------------------------------------------------------------------------
module min_window_distinct_cover #(
    parameter int MAX_TEXT = 4096,
    parameter int ALPHABET = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          operation,
    input  logic [mwdc_pkg::SYM_W-1:0]    symbol,
    input  logic                          last,
    output logic                          empty,
    input  logic                          pop,
    output logic                          found,
    output logic [mwdc_pkg::START_W-1:0]  window_start,
    output logic [mwdc_pkg::LEN_W-1:0]    window_length,
    output logic                          overflow
);
    import mwdc_pkg::*;

    logic take;
    logic q_push;
    cmd_t q_wr_data;
    cmd_t q_rd_data;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic res_valid;

    assign take  = push && !q_full;
    assign full  = q_full;
    assign empty = !res_valid;

    // classify incoming bytes
    mwdc_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .operation (operation),
        .symbol    (symbol),
        .last      (last),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    // command queue
    mwdc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // search engine
    mwdc_back #(
        .MAX_TEXT (MAX_TEXT),
        .ALPHABET (ALPHABET)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .res_pop   (pop && res_valid),
        .res_valid (res_valid),
        .res_found (found),
        .res_start (window_start),
        .res_len   (window_length),
        .res_ovf   (overflow)
    );

    // queue fill state is consistent
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("command queue both full and empty");

    // the back only takes commands that exist
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command taken from an empty queue");

    // a found window has a length
    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && found) |-> (window_length != '0))
        else $error("found window with zero length");

    // no window reports zero start and length
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !found) |-> ((window_start == '0) && (window_length == '0)))
        else $error("missing window with nonzero start or length");

endmodule

@@ tb/sv/mwdc_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mwdc_tb_pkg
// Item codes shared by the stimulus and the checker of the window search.
// ----------------------------------------------------------------------------
package mwdc_tb_pkg;

    // operation field of one input item
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

endpackage

@@ tb/sv/mwdc_window_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mwdc_window_checker
// Watches the item and result ports of the window search, keeps its own copy of the
// need table and the text buffer, predicts each result and compares it field
// by field with what the block hands out.
// ----------------------------------------------------------------------------
module mwdc_window_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          operation,
    input  logic [mwdc_pkg::SYM_W-1:0]    symbol,
    input  logic                          last,
    input  logic                          empty,
    input  logic                          pop,
    input  logic                          found,
    input  logic [mwdc_pkg::START_W-1:0]  window_start,
    input  logic [mwdc_pkg::LEN_W-1:0]    window_length,
    input  logic                          overflow,
    output int                            errors,
    output int                            pending
);

    import mwdc_pkg::*;
    import mwdc_tb_pkg::*;

    localparam int TEXT_CAP = 4096;
    localparam int ALPHA    = 256;
    localparam int NEED_SAT = TEXT_CAP + 1;

    // one predicted result
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               ovf;
    } window_t;

    // search state
    int              need_tbl [ALPHA];
    logic [SYM_W-1:0] text_mem [TEXT_CAP];
    int unsigned     kinds_missing;
    int unsigned     lo_ptr;
    int unsigned     hi_ptr;
    int unsigned     short_start;
    int unsigned     short_len;
    bit              ovf_flag;

    window_t window_q [$];
    window_t want;
    window_t got;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // forget the current search
    task automatic clear_window();
        foreach (need_tbl[i])
            need_tbl[i] = 0;
        kinds_missing = 0;
        lo_ptr        = 0;
        hi_ptr        = 0;
        short_start   = 0;
        short_len     = 0;
        ovf_flag      = 1'b0;
    endtask

    // pattern byte: raise its need, saturating one above the text capacity
    task automatic take_pattern(input logic [SYM_W-1:0] s);
        if (hi_ptr != 0)
            return;
        if (need_tbl[s] >= NEED_SAT - 1)
        begin
            need_tbl[s] = NEED_SAT;
            ovf_flag    = 1'b1;
            return;
        end
        if (need_tbl[s] == 0)
            kinds_missing++;
        need_tbl[s]++;
    endtask

    // text byte: buffer it and, while kinds are missing, lower its need, then shrink from the left
    task automatic take_text(input logic [SYM_W-1:0] s);
        int unsigned span;
        logic [SYM_W-1:0] drop;
        if (hi_ptr >= TEXT_CAP)
        begin
            ovf_flag = 1'b1;
            return;
        end
        text_mem[hi_ptr] = s;
        if (kinds_missing != 0)
        begin
            need_tbl[s]--;
            if (need_tbl[s] == 0)
                kinds_missing--;
            while (kinds_missing == 0 && lo_ptr <= hi_ptr)
            begin
                span = hi_ptr - lo_ptr + 1;
                if (short_len == 0 || span < short_len)
                begin
                    short_len   = span;
                    short_start = lo_ptr;
                end
                drop = text_mem[lo_ptr];
                need_tbl[drop]++;
                if (need_tbl[drop] > 0)
                    kinds_missing++;
                lo_ptr++;
            end
        end
        hi_ptr++;
    endtask

    task automatic check_field(input string name, input logic [LEN_W-1:0] exp_val,
                               input logic [LEN_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            window_q.delete();
        end
        else
        begin
            // input transfer
            if (push && !full)
            begin
                if (operation == OP_PATTERN)
                    take_pattern(symbol);
                else
                begin
                    take_text(symbol);
                    if (last)
                    begin
                        want.found  = (short_len != 0);
                        want.start  = want.found ? START_W'(short_start) : '0;
                        want.length = want.found ? LEN_W'(short_len) : '0;
                        want.ovf    = ovf_flag;
                        window_q.push_back(want);
                        clear_window();
                    end
                end
            end

            // result transfer
            if (pop && !empty)
            begin
                got.found  = found;
                got.start  = window_start;
                got.length = window_length;
                got.ovf    = overflow;
                if (window_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, got.found, got.start, got.length, got.ovf);
                end
                else
                begin
                    want = window_q.pop_front();
                    check_field("found", LEN_W'(want.found), LEN_W'(got.found));
                    check_field("window_start", LEN_W'(want.start), LEN_W'(got.start));
                    check_field("window_length", want.length, got.length);
                    check_field("overflow", LEN_W'(want.ovf), LEN_W'(got.ovf));
                end
            end
        end
        pending <= window_q.size();
    end

endmodule

@@ tb/sv/tb_min_window_distinct_cover.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_window_distinct_cover
// Drives pattern and text bytes into the window search with random gaps and
// a long result stall, while a checker beside the block predicts and
// compares every result; gives the verdict at the end.
// ----------------------------------------------------------------------------
module tb_min_window_distinct_cover;

    import mwdc_pkg::*;
    import mwdc_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_NS     = 40_000_000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               operation = 1'b0;
    logic [SYM_W-1:0]   symbol    = '0;
    logic               last      = 1'b0;
    logic               pop       = 1'b0;
    logic               full;
    logic               empty;
    logic               found;
    logic [START_W-1:0] window_start;
    logic [LEN_W-1:0]   window_length;
    logic               overflow;
    int                 errors;
    int                 pending;

    // shared between stimulus and receiver
    bit quiet     = 1'b0;
    bit gap_mode  = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int items_sent = 0;

    min_window_distinct_cover dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .symbol        (symbol),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .found         (found),
        .window_start  (window_start),
        .window_length (window_length),
        .overflow      (overflow)
    );

    mwdc_window_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .symbol        (symbol),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .found         (found),
        .window_start  (window_start),
        .window_length (window_length),
        .overflow      (overflow),
        .errors        (errors),
        .pending       (pending)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop
    initial
    begin
        #(LIMIT_NS);
        $display("min_window_distinct_cover regression: fail");
        $finish;
    end

    // one input transfer, then maybe an idle burst
    task automatic send_item(input logic op, input logic [SYM_W-1:0] s, input logic lst,
                             input bit counts);
        operation <= op;
        symbol    <= s;
        last      <= lst;
        push      <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (counts)
            items_sent++;
        if (!quiet && gap_mode && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    // symbol near a per-search base, sometimes anywhere
    function automatic logic [SYM_W-1:0] pick_symbol(input logic [SYM_W-1:0] base,
                                                     input int spread);
        if ($urandom_range(0, 9) == 0)
            return SYM_W'($urandom);
        return base + SYM_W'($urandom_range(0, spread - 1));
    endfunction

    // result side: bursts of pop and idle, one long hold-off on request
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 14))
                    @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20))
                    @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [SYM_W-1:0] base;
        int spread;
        int shape;
        int plen;
        int tlen;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern: bytes only buffered
        gap_mode = 1'b1;
        send_item(OP_TEXT, 8'h00, 1'b0, 0);
        send_item(OP_TEXT, 8'hFF, 1'b1, 0);

        // last on a pattern byte, and a pattern byte after text
        send_item(OP_PATTERN, 8'h41, 1'b1, 0);
        send_item(OP_PATTERN, 8'h42, 1'b0, 0);
        send_item(OP_TEXT, 8'h42, 1'b0, 0);
        send_item(OP_PATTERN, 8'h43, 1'b0, 0);
        send_item(OP_TEXT, 8'h41, 1'b1, 0);

        // equal windows keep the earliest
        send_item(OP_PATTERN, 8'h01, 1'b0, 0);
        send_item(OP_TEXT, 8'h01, 1'b0, 0);
        send_item(OP_TEXT, 8'h02, 1'b0, 0);
        send_item(OP_TEXT, 8'h01, 1'b1, 0);

        // repeated pattern symbols
        send_item(OP_PATTERN, 8'hAA, 1'b0, 0);
        send_item(OP_PATTERN, 8'hAA, 1'b0, 0);
        send_item(OP_PATTERN, 8'h55, 1'b0, 0);
        send_item(OP_TEXT, 8'hAA, 1'b0, 0);
        send_item(OP_TEXT, 8'h55, 1'b0, 0);
        send_item(OP_TEXT, 8'h00, 1'b0, 0);
        send_item(OP_TEXT, 8'hAA, 1'b0, 0);
        send_item(OP_TEXT, 8'hAA, 1'b0, 0);
        send_item(OP_TEXT, 8'h55, 1'b1, 0);

        // no covering window
        send_item(OP_PATTERN, 8'h80, 1'b0, 0);
        send_item(OP_TEXT, 8'h7F, 1'b1, 0);

        // random searches, long result stall at the start
        hold_req = 1'b1;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent > RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            gap_mode = ($urandom_range(0, 3) != 0);
            base     = SYM_W'($urandom);
            spread   = $urandom_range(1, 8);
            shape    = $urandom_range(0, 9);
            plen     = (shape == 0) ? 0 : $urandom_range(1, 6);
            tlen     = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 120)
                                                    : $urandom_range(1, 40);
            for (int i = 0; i < plen; i++)
                send_item(OP_PATTERN, pick_symbol(base, spread), $urandom_range(0, 7) == 0, 1);
            for (int i = 0; i < tlen; i++)
            begin
                // broken sequence: stray pattern bytes inside the text
                if (shape == 1 && $urandom_range(0, 4) == 0)
                    send_item(OP_PATTERN, SYM_W'($urandom), $urandom_range(0, 1) == 1, 0);
                send_item(OP_TEXT, pick_symbol(base, spread), i == tlen - 1, 1);
            end
        end
        quiet = 1'b1;
        push <= 1'b0;

        // drain, once the checker has seen the last transfer
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("min_window_distinct_cover regression: pass");
        else
            $display("min_window_distinct_cover regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mwdc_pkg.sv
rtl/mwdc_front.sv
rtl/mwdc_queue.sv
rtl/mwdc_back.sv
rtl/min_window_distinct_cover.sv
tb/sv/mwdc_tb_pkg.sv
tb/sv/mwdc_window_checker.sv
tb/sv/tb_min_window_distinct_cover.sv
